// ===== src/top_k_weighted_choice_picker_assert.svh =====
// Assertion macros shared by the checker file of the top-k weighted choice picker.
`ifndef TOP_K_WEIGHTED_CHOICE_PICKER_ASSERT_SVH
`define TOP_K_WEIGHTED_CHOICE_PICKER_ASSERT_SVH

// Checked on every clock edge while reset is released.
`define TKWC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("top-k picker assertion failed");

// Checked on every clock edge, reset included.
`define TKWC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("top-k picker reset assertion failed");

`endif

// ===== src/tkwc_pkg.sv =====
// Shared constants for the top-k weighted choice picker.
package tkwc_pkg;

    // Store size and the index and count widths that follow from it.
    localparam int MAX_CHOICES = 32;
    localparam int IDX_W       = $clog2(MAX_CHOICES);
    localparam int CNT_W       = $clog2(MAX_CHOICES + 1);

    // Score and momentum formats.
    localparam int IN_W    = 18;
    localparam int SCORE_W = 17;
    localparam int MOM_W   = 16;
    localparam int FRAC_W  = 12;
    localparam int FACT_W  = MOM_W + 1;
    localparam int BPROD_W = SCORE_W + FACT_W;
    localparam int BOOST_W = BPROD_W - FRAC_W;

    // Ranking and draw widths.
    localparam int TOPC_W  = 6;
    localparam int CMP_W   = (CNT_W > TOPC_W) ? CNT_W : TOPC_W;
    localparam int SUM_W   = SCORE_W + IDX_W;
    localparam int SEQ_W   = 32;
    localparam int RND_W   = 24;
    localparam int DPROD_W = RND_W + SUM_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [SCORE_W-1:0] ONE_Q16     = SCORE_W'(65536);
    localparam logic [CNT_W-1:0]   CHOICE_NONE = CNT_W'(MAX_CHOICES);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_MODE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_SEED = CFG_IDX_W'(3);

endpackage

// ===== src/top_k_weighted_choice_picker.sv =====
// Top level of the top-k weighted choice picker: score store, ranking sequencer and draw.
//
// Usage: scores enter on the input channel (i_in_valid / o_in_stall), one per cycle, and
// are clamped to 0..1.0 in Q1.16. A score with i_last set closes the round; the block
// then stalls its input while it ranks and picks, and one result per round leaves on the
// output channel (o_out_valid / i_out_stall). Registers are written on the config channel
// (i_cfg_valid / o_cfg_ready, always ready) while the block is idle.
// After the closing score the block boosts the current choice, ranks, draws in weighted
// mode and publishes. In best mode one ranking pass finds the winner. In weighted mode
// each ranking pass finds one entry, at most top_count of them; a final pass that finds
// none ends the ranking and is skipped once top_count entries are found. Each ranking pass
// walks the score memory through its single read port, one entry per cycle, which sets the
// throughput.
// A result that the receiver stalls waits in the output register; the next round loads
// meanwhile and its pick waits only if that register is still full.
// Reset (synchronous, active low) empties the store, forgets the current choice, returns
// the registers to momentum 0, best mode, top count 1 and draw sequence 1.
module top_k_weighted_choice_picker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Score input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [tkwc_pkg::IN_W-1:0]   i_score,
    input  logic                               i_last,
    // Result output channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_found,
    output logic [tkwc_pkg::IDX_W-1:0]         o_chosen_index,
    output logic [tkwc_pkg::SCORE_W-1:0]       o_chosen_score,
    output logic                               o_kept_current,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tkwc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tkwc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tkwc_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_MULB,
        S_SATB,
        S_SCAN,
        S_RANKED,
        S_DRAW,
        S_DMUL,
        S_WALK,
        S_EMIT
    } t_state;

    t_state                 r_state;

    // Configuration registers and the draw sequence.
    logic [MOM_W-1:0]       r_momentum;
    logic                   r_mode;
    logic [TOPC_W-1:0]      r_top;
    logic [SEQ_W-1:0]       r_seq;

    // Round bookkeeping.
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_cur;
    logic [SCORE_W-1:0]     r_cur_s;
    logic [BPROD_W-1:0]     r_bprod;
    logic [SCORE_W-1:0]     r_cur_w;

    // Score memory and its read pipeline.
    logic [SCORE_W-1:0]     r_mem [MAX_CHOICES];
    logic [SCORE_W-1:0]     r_mem_q;
    logic [CNT_W-1:0]       r_addr;
    logic                   r_q_vld;
    logic [IDX_W-1:0]       r_q_idx;

    // Ranking state.
    logic [SCORE_W-1:0]     r_best_w;
    logic [IDX_W-1:0]       r_best_idx;
    logic [MAX_CHOICES-1:0] r_used;
    logic [CNT_W-1:0]       r_nrank;
    logic [SUM_W-1:0]       r_total;
    logic [IDX_W-1:0]       r_rank_idx [MAX_CHOICES];
    logic [SCORE_W-1:0]     r_rank_w   [MAX_CHOICES];

    // Draw state.
    logic [RND_W-1:0]       r_rnd;
    logic [DPROD_W-1:0]     r_dprod;
    logic [CNT_W-1:0]       r_walk;
    logic [SUM_W-1:0]       r_cum;

    // Picked choice and the output register.
    logic                   r_pick_found;
    logic [IDX_W-1:0]       r_pick_idx;
    logic [SCORE_W-1:0]     r_pick_w;
    logic                   r_out_valid;
    logic                   r_out_found;
    logic [IDX_W-1:0]       r_out_idx;
    logic [SCORE_W-1:0]     r_out_score;
    logic                   r_out_kept;

    // Combinational helpers.
    logic                   n_accept;
    logic                   n_room;
    logic [SCORE_W-1:0]     n_clamp;
    logic [FACT_W-1:0]      n_factor;
    logic [BOOST_W-1:0]     n_boost;
    logic [SCORE_W-1:0]     n_q_w;
    logic                   n_q_take;
    logic                   n_scan_end;
    logic [CMP_W-1:0]       n_rank_next;
    logic [CMP_W-1:0]       n_k_eff;
    logic [SEQ_W-1:0]       n_seq_a;
    logic [SEQ_W-1:0]       n_seq_b;
    logic [SEQ_W-1:0]       n_seq;
    logic [SCORE_W-1:0]     n_walk_w;
    logic [SUM_W-1:0]       n_cum;
    logic                   n_walk_hit;
    logic                   n_walk_last;
    logic                   n_out_free;
    logic                   n_pick_cur;

    assign o_in_stall     = (r_state != S_LOAD);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_chosen_index = r_out_idx;
    assign o_chosen_score = r_out_score;
    assign o_kept_current = r_out_kept;

    // Input transaction and clamp of the raw score to 0..1.0.
    assign n_accept = i_in_valid && (r_state == S_LOAD);
    assign n_room   = (r_count < CNT_W'(MAX_CHOICES));
    always_comb begin
        if (i_score[IN_W-1]) begin
            n_clamp = '0;
        end else if (i_score[IN_W-2:0] > ONE_Q16) begin
            n_clamp = ONE_Q16;
        end else begin
            n_clamp = i_score[SCORE_W-1:0];
        end
    end

    // Momentum boost of the current choice, saturated to 1.0.
    assign n_factor = FACT_W'(1 << FRAC_W) + FACT_W'(r_momentum);
    assign n_boost  = r_bprod[BPROD_W-1:FRAC_W];

    // Scan compare: the current choice reads its boosted weight.
    assign n_q_w      = (r_cur == CNT_W'(r_q_idx)) ? r_cur_w : r_mem_q;
    assign n_q_take   = r_q_vld && !r_used[r_q_idx] && (n_q_w > r_best_w);
    assign n_scan_end = (r_addr == r_count) && !r_q_vld;

    // Number of ranked entries wanted: one in best mode, top count (at least one) else.
    assign n_rank_next = CMP_W'(r_nrank) + CMP_W'(1);
    always_comb begin
        if (!r_mode || (r_top == '0)) begin
            n_k_eff = CMP_W'(1);
        end else begin
            n_k_eff = CMP_W'(r_top);
        end
    end

    // One xorshift32 step.
    assign n_seq_a = r_seq ^ (r_seq << 13);
    assign n_seq_b = n_seq_a ^ (n_seq_a >> 17);
    assign n_seq   = n_seq_b ^ (n_seq_b << 5);

    // Roulette walk over the ranked list.
    assign n_walk_w    = r_rank_w[r_walk[IDX_W-1:0]];
    assign n_cum       = r_cum + SUM_W'(n_walk_w);
    assign n_walk_hit  = (r_dprod <= {n_cum, RND_W'(0)});
    assign n_walk_last = (r_walk == (r_nrank - CNT_W'(1)));

    assign n_out_free = !r_out_valid || !i_out_stall;
    assign n_pick_cur = (CNT_W'(r_pick_idx) == r_cur);

    // Score memory write and registered read; ranked list write.
    always_ff @(posedge i_clk) begin
        if (n_accept && n_room) begin
            r_mem[r_count[IDX_W-1:0]] <= n_clamp;
        end
        r_mem_q <= r_mem[r_addr[IDX_W-1:0]];
        if ((r_state == S_SCAN) && n_scan_end && (r_best_w != '0)) begin
            r_rank_idx[r_nrank[IDX_W-1:0]] <= r_best_idx;
            r_rank_w[r_nrank[IDX_W-1:0]]   <= r_best_w;
        end
    end

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_momentum  <= '0;
            r_mode      <= 1'b0;
            r_top       <= TOPC_W'(1);
            r_seq       <= SEQ_W'(1);
            r_count     <= '0;
            r_cur       <= CHOICE_NONE;
            r_out_valid <= 1'b0;
            r_q_vld     <= 1'b0;
            r_addr      <= '0;
        end else begin
            // An accepted result leaves the output register unless a new one replaces it.
            if (!i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (n_accept) begin
                        if (n_room) begin
                            r_count <= r_count + CNT_W'(1);
                            if (r_count == r_cur) begin
                                r_cur_s <= n_clamp;
                            end
                        end
                        if (i_last) begin
                            r_used  <= '0;
                            r_nrank <= '0;
                            r_total <= '0;
                            r_state <= S_MULB;
                        end
                    end
                end
                S_MULB: begin
                    r_bprod <= BPROD_W'(r_cur_s) * BPROD_W'(n_factor);
                    r_state <= S_SATB;
                end
                S_SATB: begin
                    if (n_boost > BOOST_W'(ONE_Q16)) begin
                        r_cur_w <= ONE_Q16;
                    end else begin
                        r_cur_w <= n_boost[SCORE_W-1:0];
                    end
                    r_addr   <= '0;
                    r_q_vld  <= 1'b0;
                    r_best_w <= '0;
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    // Issue one memory read per cycle.
                    if (r_addr < r_count) begin
                        r_addr  <= r_addr + CNT_W'(1);
                        r_q_vld <= 1'b1;
                        r_q_idx <= r_addr[IDX_W-1:0];
                    end else begin
                        r_q_vld <= 1'b0;
                    end
                    // Strictly greater keeps a tie on the lower index.
                    if (n_q_take) begin
                        r_best_w   <= n_q_w;
                        r_best_idx <= r_q_idx;
                    end
                    // End of pass: append the winner or stop when none is left.
                    if (n_scan_end) begin
                        if (r_best_w == '0) begin
                            r_state <= S_RANKED;
                        end else begin
                            r_used[r_best_idx] <= 1'b1;
                            r_total  <= r_total + SUM_W'(r_best_w);
                            r_nrank  <= r_nrank + CNT_W'(1);
                            r_addr   <= '0;
                            r_best_w <= '0;
                            if (n_rank_next == n_k_eff) begin
                                r_state <= S_RANKED;
                            end
                        end
                    end
                end
                S_RANKED: begin
                    if (r_nrank == '0) begin
                        r_pick_found <= 1'b0;
                        r_pick_idx   <= '0;
                        r_pick_w     <= '0;
                        r_state      <= S_EMIT;
                    end else if (!r_mode) begin
                        r_pick_found <= 1'b1;
                        r_pick_idx   <= r_rank_idx[0];
                        r_pick_w     <= r_rank_w[0];
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    r_seq   <= n_seq;
                    r_rnd   <= n_seq[SEQ_W-1:SEQ_W-RND_W];
                    r_state <= S_DMUL;
                end
                S_DMUL: begin
                    r_dprod <= DPROD_W'(r_rnd) * DPROD_W'(r_total);
                    r_walk  <= '0;
                    r_cum   <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_cum <= n_cum;
                    if (n_walk_hit || n_walk_last) begin
                        r_pick_found <= 1'b1;
                        r_pick_idx   <= r_rank_idx[r_walk[IDX_W-1:0]];
                        r_pick_w     <= n_walk_w;
                        r_state      <= S_EMIT;
                    end else begin
                        r_walk <= r_walk + CNT_W'(1);
                    end
                end
                S_EMIT: begin
                    // Wait for the output register, then publish and start a new round.
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_pick_found;
                        r_out_idx   <= r_pick_idx;
                        r_out_score <= (r_pick_found && n_pick_cur) ? r_cur_s : r_pick_w;
                        r_out_kept  <= r_pick_found && n_pick_cur;
                        r_cur       <= r_pick_found ? CNT_W'(r_pick_idx) : CHOICE_NONE;
                        r_count     <= '0;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            // Register writes must arrive only while the block is idle; the block itself does not enforce it.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MOMENTUM:  r_momentum <= i_cfg_data[MOM_W-1:0];
                    CFG_PICK_MODE: r_mode     <= i_cfg_data[0];
                    CFG_TOP_COUNT: r_top      <= i_cfg_data[TOPC_W-1:0];
                    CFG_DRAW_SEED: r_seq      <= i_cfg_data | SEQ_W'(1);
                endcase
            end
        end
    end

endmodule

// ===== src/tkwc_checker.sv =====
// Port-level checker for the top-k weighted choice picker and its bind statement.
`include "top_k_weighted_choice_picker_assert.svh"

module tkwc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               i_last,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_found,
    input logic [tkwc_pkg::IDX_W-1:0]         o_chosen_index,
    input logic [tkwc_pkg::SCORE_W-1:0]       o_chosen_score,
    input logic                               o_kept_current
);
    import tkwc_pkg::*;

    // Reset leaves no result pending and the input open.
    `TKWC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out_valid && !o_in_stall)

    // A closing score stops the input while the round is ranked.
    `TKWC_ASSERT(a_last_closes_round, i_in_valid && !o_in_stall && i_last |=> o_in_stall)

    // An empty round reports all fields as zero.
    `TKWC_ASSERT(a_none_is_zero, o_out_valid && !o_found |-> o_chosen_index == '0 && o_chosen_score == '0 && !o_kept_current)

    // A picked choice always carries a positive score no larger than one.
    `TKWC_ASSERT(a_found_positive, o_out_valid && o_found |-> o_chosen_score != '0 && o_chosen_score <= ONE_Q16)

    // A stalled result stays on the port unchanged.
    `TKWC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_chosen_index) && $stable(o_chosen_score) && $stable(o_found))

endmodule

bind top_k_weighted_choice_picker tkwc_checker u_tkwc_checker (.*);

// ===== tb/tb_top_k_weighted_choice_picker.sv =====
// Self-checking testbench for the top-k weighted choice picker.
`timescale 1ns / 100ps

module tb_top_k_weighted_choice_picker;
    import tkwc_pkg::*;

    // One result transaction, field by field.
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   index;
        logic [SCORE_W-1:0] score;
        logic               kept;
    } t_pick;

    // One row of the directed table: a register write or a run of scores.
    typedef struct {
        bit                         is_cfg;
        logic [CFG_IDX_W-1:0]       cfg_index;
        logic [CFG_DATA_W-1:0]      cfg_data;
        logic signed [IN_W-1:0]     score;
        bit                         last;
        int                         reps;
        bit                         typed;
        t_pick                      want;
    } t_stim_row;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    localparam int DRAIN_CYCLES = 1200;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [IN_W-1:0]      i_score;
    logic                        i_last;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic                        o_found;
    logic [IDX_W-1:0]            o_chosen_index;
    logic [SCORE_W-1:0]          o_chosen_score;
    logic                        o_kept_current;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;

    top_k_weighted_choice_picker u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_score        (i_score),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_chosen_index (o_chosen_index),
        .o_chosen_score (o_chosen_score),
        .o_kept_current (o_kept_current),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Predictor state: registers, the score store and the draw sequence.
    logic [MOM_W-1:0]    momentum_reg;
    logic                weighted_mode;
    logic [TOPC_W-1:0]   top_k_reg;
    logic [SEQ_W-1:0]    draw_state;
    logic [SCORE_W-1:0]  round_scores [MAX_CHOICES];
    int                  loaded_cnt;
    int                  current_pick;

    t_pick               pending_picks [$];
    int                  err_count;
    int                  burst_left;
    bit                  gap_free;
    t_stall_mode         stall_mode;
    int                  stall_left;
    int                  stall_tick;
    t_stim_row           directed_rows [$];

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A generous ceiling on the whole run.
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // Clamp a raw signed Q1.16 score into 0..1.0.
    function automatic logic [SCORE_W-1:0] clamp_to_unit(input logic signed [IN_W-1:0] raw);
        if (raw < 0) begin
            return '0;
        end
        if (raw > $signed({1'b0, ONE_Q16})) begin
            return ONE_Q16;
        end
        return raw[SCORE_W-1:0];
    endfunction

    // Rank the loaded scores and pick one; returns MAX_CHOICES when nothing is positive.
    function automatic int rank_and_pick();
        logic [SCORE_W-1:0]   wt [MAX_CHOICES];
        int                   order [MAX_CHOICES];
        int                   n_ranked;
        int                   j;
        int                   keep;
        logic [BPROD_W-1:0]   boosted;
        logic [63:0]          total;
        logic [63:0]          cum;
        logic [63:0]          scaled_draw;
        n_ranked = 0;
        for (int i = 0; i < loaded_cnt; i++) begin
            wt[i] = round_scores[i];
            if (i == current_pick) begin
                boosted = ({{FACT_W{1'b0}}, round_scores[i]} *
                           (BPROD_W'(4096) + BPROD_W'(momentum_reg))) >> FRAC_W;
                wt[i] = (boosted > BPROD_W'(ONE_Q16)) ? ONE_Q16 : boosted[SCORE_W-1:0];
            end
        end
        // Insertion sort, descending; a strict compare keeps ties in index order.
        for (int i = 0; i < loaded_cnt; i++) begin
            if (wt[i] != 0) begin
                j = n_ranked;
                while (j > 0 && wt[order[j-1]] < wt[i]) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
                n_ranked++;
            end
        end
        if (n_ranked == 0) begin
            return MAX_CHOICES;
        end
        if (!weighted_mode) begin
            return order[0];
        end
        // Roulette draw among the top K, compared exactly in integers.
        keep = (top_k_reg == 0) ? 1 : int'(top_k_reg);
        if (keep < n_ranked) begin
            n_ranked = keep;
        end
        total = 0;
        for (int i = 0; i < n_ranked; i++) begin
            total += 64'(wt[order[i]]);
        end
        draw_state = draw_state ^ (draw_state << 13);
        draw_state = draw_state ^ (draw_state >> 17);
        draw_state = draw_state ^ (draw_state << 5);
        scaled_draw = 64'(draw_state >> 8) * total;
        cum = 0;
        for (int i = 0; i < n_ranked; i++) begin
            cum += 64'(wt[order[i]]);
            if (scaled_draw <= (cum << 24)) begin
                return order[i];
            end
        end
        return order[n_ranked-1];
    endfunction

    // Take one accepted score; returns 1 with the expected pick when the round closes.
    function automatic bit accept_score(input logic signed [IN_W-1:0] raw, input bit last,
                                        output t_pick res);
        int prev;
        int chosen;
        res = '0;
        if (loaded_cnt < MAX_CHOICES) begin
            round_scores[loaded_cnt] = clamp_to_unit(raw);
            loaded_cnt++;
        end
        if (!last) begin
            return 1'b0;
        end
        prev = current_pick;
        chosen = rank_and_pick();
        loaded_cnt = 0;
        if (chosen >= MAX_CHOICES) begin
            current_pick = MAX_CHOICES;
            return 1'b1;
        end
        current_pick = chosen;
        res.found = 1'b1;
        res.index = IDX_W'(chosen);
        res.score = round_scores[chosen];
        res.kept  = (chosen == prev);
        return 1'b1;
    endfunction

    // Send one score transaction; bursts with random gaps. Entered and left at a falling edge.
    task automatic send_score(input logic signed [IN_W-1:0] raw, input bit last,
                              input bit use_typed, input t_pick typed_pick);
        int    gap;
        t_pick predicted;
        if (burst_left == 0) begin
            gap = (gap_free || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_in_valid = 1'b1;
        i_score    = raw;
        i_last     = last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (accept_score(raw, last, predicted)) begin
            pending_picks = {pending_picks, (use_typed ? typed_pick : predicted)};
        end
        burst_left--;
        @(negedge i_clk);
    endtask

    // Write one register transaction and mirror it into the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_MOMENTUM:  momentum_reg  = data[MOM_W-1:0];
            CFG_PICK_MODE: weighted_mode = data[0];
            CFG_TOP_COUNT: top_k_reg     = data[TOPC_W-1:0];
            CFG_DRAW_SEED: draw_state    = data | 32'd1;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Let every expected pick arrive, then give the block its full latency to settle.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_stim_row score_row(input logic signed [IN_W-1:0] raw, input bit last,
                                            input int reps);
        t_stim_row r;
        r = '{default: '0};
        r.score = raw;
        r.last  = last;
        r.reps  = reps;
        return r;
    endfunction

    function automatic t_stim_row checked_row(input logic signed [IN_W-1:0] raw,
                                              input t_pick want);
        t_stim_row r;
        r = score_row(raw, 1'b1, 1);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = '{default: '0};
        r.is_cfg    = 1'b1;
        r.cfg_index = index;
        r.cfg_data  = data;
        return r;
    endfunction

    // Append one row to the end of the directed table.
    function automatic void add_row(input t_stim_row r);
        directed_rows = {directed_rows, r};
    endfunction

    // Receiver stall pattern: stretches of none, light, heavy and periodic stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall = 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:     i_out_stall = 1'b0;
                STALL_LIGHT:    i_out_stall = ($urandom_range(0, 99) < 30);
                STALL_HEAVY:    i_out_stall = ($urandom_range(0, 99) < 85);
                STALL_PERIODIC: i_out_stall = (stall_tick % 4 != 0);
                default:        i_out_stall = 1'b0;
            endcase
        end
    end

    // Compare each result transaction with the oldest expected pick.
    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_picks.size() == 0) begin
                report_mismatch($sformatf("result with none expected: index %0d",
                                          o_chosen_index));
            end else begin
                want = pending_picks.pop_front();
                if (o_found !== want.found)
                    report_mismatch($sformatf("found %b, expected %b", o_found, want.found));
                if (o_chosen_index !== want.index)
                    report_mismatch($sformatf("chosen_index %0d, expected %0d",
                                              o_chosen_index, want.index));
                if (o_chosen_score !== want.score)
                    report_mismatch($sformatf("chosen_score %0d, expected %0d",
                                              o_chosen_score, want.score));
                if (o_kept_current !== want.kept)
                    report_mismatch($sformatf("kept_current %b, expected %b",
                                              o_kept_current, want.kept));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial begin
        t_stim_row              row;
        int                     phase_items;
        int                     round_len;
        logic signed [IN_W-1:0] raw;
        logic signed [IN_W-1:0] prev_raw;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_score     = '0;
        i_last      = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MOMENTUM;
        i_cfg_data  = '0;
        err_count   = 0;
        burst_left  = 0;
        gap_free    = 1'b0;
        stall_mode  = STALL_NONE;
        stall_left  = 0;
        stall_tick  = 0;
        prev_raw    = '0;

        // Predictor reset state.
        momentum_reg  = '0;
        weighted_mode = 1'b0;
        top_k_reg     = TOPC_W'(1);
        draw_state    = 32'd1;
        loaded_cnt    = 0;
        current_pick  = MAX_CHOICES;
        foreach (round_scores[i]) round_scores[i] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Best mode from reset: empty pick, clamping extremes, ties, a full store.
        add_row(checked_row(18'sd0, '{1'b0, 5'd0, 17'd0, 1'b0}));
        add_row(score_row(-18'sd131072, 1'b0, 1));
        add_row(checked_row(18'sd131071, '{1'b1, 5'd1, 17'd65536, 1'b0}));
        add_row(score_row(-18'sd1, 1'b0, 1));
        add_row(score_row(18'sd65537, 1'b0, 1));
        add_row(score_row(18'sd65536, 1'b0, 1));
        add_row(checked_row(18'sd1, '{1'b1, 5'd1, 17'd65536, 1'b1}));
        add_row(score_row(18'sd100, 1'b0, 31));
        add_row(score_row(18'sd200, 1'b0, 1));
        add_row(checked_row(18'sd65536, '{1'b1, 5'd31, 17'd200, 1'b0}));
        // The current choice lies beyond this short round.
        add_row(score_row(18'sd10, 1'b0, 1));
        add_row(checked_row(18'sd20, '{1'b1, 5'd1, 17'd20, 1'b0}));
        // Largest momentum boosts the running choice past a higher score.
        add_row(cfg_row(CFG_MOMENTUM, 32'd65535));
        add_row(score_row(18'sd30000, 1'b0, 1));
        add_row(score_row(18'sd20000, 1'b0, 1));
        add_row(score_row(18'sd40000, 1'b1, 1));
        // Weighted mode with a top count of zero, then a top count above the ranked count.
        add_row(cfg_row(CFG_PICK_MODE, 32'd1));
        add_row(cfg_row(CFG_TOP_COUNT, 32'd0));
        add_row(cfg_row(CFG_DRAW_SEED, 32'd0));
        add_row(score_row(18'sd5000, 1'b0, 1));
        add_row(score_row(18'sd6000, 1'b1, 1));
        add_row(cfg_row(CFG_TOP_COUNT, 32'd63));
        add_row(cfg_row(CFG_DRAW_SEED, 32'hFFFF_FFFF));
        add_row(score_row(18'sd1000, 1'b0, 1));
        add_row(score_row(18'sd50000, 1'b0, 1));
        add_row(score_row(18'sd0, 1'b0, 1));
        add_row(score_row(18'sd30000, 1'b1, 1));
        // Nothing positive in weighted mode: no draw is taken.
        add_row(score_row(-18'sd5, 1'b0, 1));
        add_row(checked_row(18'sd0, '{1'b0, 5'd0, 17'd0, 1'b0}));

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.is_cfg) begin
                wait_idle();
                write_reg(row.cfg_index, row.cfg_data);
            end else begin
                for (int r = 0; r < row.reps; r++) begin
                    send_score(row.score, row.last && (r == row.reps - 1), row.typed, row.want);
                end
            end
        end

        // Random phases, each with its own register setting.
        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_MOMENTUM, 32'd0);
                1:       write_reg(CFG_MOMENTUM, 32'd65535);
                default: write_reg(CFG_MOMENTUM, 32'($urandom_range(0, 65535)));
            endcase
            write_reg(CFG_PICK_MODE, 32'(phase % 2));
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_TOP_COUNT, 32'd0);
                1:       write_reg(CFG_TOP_COUNT, 32'd1);
                2:       write_reg(CFG_TOP_COUNT, 32'd2);
                3:       write_reg(CFG_TOP_COUNT, 32'd32);
                4:       write_reg(CFG_TOP_COUNT, 32'd63);
                default: write_reg(CFG_TOP_COUNT, 32'($urandom_range(0, 63)));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_DRAW_SEED, 32'd0);
                1:       write_reg(CFG_DRAW_SEED, 32'hFFFF_FFFF);
                default: write_reg(CFG_DRAW_SEED, $urandom);
            endcase
            gap_free = (phase % 3 == 2);
            phase_items = 0;
            while (phase_items < 80) begin
                // Mostly short rounds, some long ones, a few that overflow the store.
                case ($urandom_range(0, 19))
                    0:                  round_len = $urandom_range(33, 40);
                    1, 2, 3, 4, 5:      round_len = $urandom_range(9, 32);
                    default:            round_len = $urandom_range(1, 8);
                endcase
                for (int k = 0; k < round_len; k++) begin
                    case ($urandom_range(0, 9))
                        0:       raw = '0;
                        1:       raw = -IN_W'($urandom_range(1, 131072));
                        2:       raw = IN_W'($urandom_range(65537, 131071));
                        3:       raw = prev_raw;
                        4:       raw = IN_W'($urandom_range(65000, 65536));
                        default: raw = IN_W'($urandom_range(0, 65536));
                    endcase
                    prev_raw = raw;
                    send_score(raw, k == round_len - 1, 1'b0, '0);
                    phase_items++;
                end
            end
        end

        // Drain and verdict.
        wait_idle();
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
